// File: design/dbts_pkg.sv
// ----------------------------------------------------------------------------
// dbts_pkg
// Shared constants and types for the direct branch target scanner.
// ----------------------------------------------------------------------------
package dbts_pkg;

    // Width of the body byte position counter
    localparam int PosBits = 32;
    // Width of the exact target sum: base, offset and signed displacement
    localparam int SumW    = 66;
    // Width of a signed displacement
    localparam int RelW    = 33;
    // Depth of the byte history window
    localparam int WinDepth = 5;

    // Architecture modes
    localparam logic [1:0] MODE_X86   = 2'd0;
    localparam logic [1:0] MODE_A64   = 2'd1;
    localparam logic [1:0] MODE_THUMB = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Match kinds
    localparam logic [1:0] KIND_X86_CALL  = 2'd0;
    localparam logic [1:0] KIND_X86_SLOT  = 2'd1;
    localparam logic [1:0] KIND_A64_B     = 2'd2;
    localparam logic [1:0] KIND_THUMB_BL  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ARCH_MODE = 1'b0;
    localparam logic CFG_BODY_BASE = 1'b1;

    // Opcode bytes and masks
    localparam logic [7:0]  X86_CALL_OP   = 8'he8;
    localparam logic [7:0]  X86_GRP5_OP   = 8'hff;
    localparam logic [7:0]  X86_MODRM_RIP = 8'h15;
    localparam logic [31:0] A64_B_MASK    = 32'h7c00_0000;
    localparam logic [31:0] A64_B_MATCH   = 32'h1400_0000;
    localparam logic [15:0] T2_HI_MASK    = 16'hf800;
    localparam logic [15:0] T2_HI_MATCH   = 16'hf000;
    localparam logic [15:0] T2_LO_MASK    = 16'hc000;

    // One result item
    typedef struct packed {
        logic [63:0] target;
        logic [1:0]  kind;
        logic [31:0] start;
        logic        last;
    } res_t;

endpackage

// File: design/direct_branch_target_scanner_unit.sv
// ----------------------------------------------------------------------------
// direct_branch_target_scanner_unit
// Scans a code body byte by byte and reports direct branch targets.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one code byte per item (tdata) and the end-of-body mark
//   (tlast). m_* carries one result item: target address and start offset in
//   tdata, match kind in tuser, and tlast on the last result of a byte.
//   cfg_we/cfg_index/cfg_data write arch_mode (0) and body_base (1); write
//   them only while no items are in flight.
// Pipeline and throughput:
//   A byte enters an input register, the matchers and a single 66-bit target
//   adder work between that register and a two-entry result buffer, and the
//   results are driven from that buffer. One byte is taken every cycle while
//   m_tready stays high; a byte that causes two results holds the input while
//   the second result drains.
// Reset:
//   aresetn (synchronous, active low) clears the window, the position, the
//   pipeline valids and sets arch_mode to no decoding and body_base to zero.
// Stall:
//   When m_tready is low the result buffer holds, the input register fills,
//   and then s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module direct_branch_target_scanner_unit
    import dbts_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] code_byte
    input  logic         s_tlast,   // last_byte
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // [63:0] target_address, [95:64] start_offset
    output logic [1:0]   m_tuser,   // [1:0] match_kind
    output logic         m_tlast    // run_last
);

    // configuration
    logic [1:0]  mode_reg;
    logic [63:0] base_reg;

    // scan state
    logic [7:0]         win_reg [WinDepth];
    logic [PosBits-1:0] pos_reg;

    // input register
    logic               s1_valid_reg;
    logic [7:0]         s1_cur_reg;
    logic [7:0]         s1_win_reg [WinDepth];
    logic [PosBits-1:0] s1_pos_reg;

    // result buffer
    logic [1:0] cnt_reg, cnt_next;
    res_t       e0_reg, e0_next, e1_reg, e1_next;

    logic s_acc, pop, load;
    logic [1:0] cnt_after_pop;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NONE;
            base_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ARCH_MODE: mode_reg <= cfg_data[1:0];
                CFG_BODY_BASE: base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign pop           = m_tvalid && m_tready;
    assign cnt_after_pop = cnt_reg - {1'b0, pop};
    assign load          = s1_valid_reg && (cnt_after_pop == 2'd0);
    assign s_tready      = !s1_valid_reg || load;
    assign s_acc         = s_tvalid && s_tready;

    // Advance window and position on each accepted item; clear both after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WinDepth; i++) win_reg[i] <= '0;
            pos_reg <= '0;
        end else if (s_acc) begin
            if (s_tlast) begin
                for (int i = 0; i < WinDepth; i++) win_reg[i] <= '0;
                pos_reg <= '0;
            end else begin
                for (int i = WinDepth - 1; i > 0; i--) win_reg[i] <= win_reg[i-1];
                win_reg[0] <= s_tdata;
                pos_reg    <= pos_reg + PosBits'(1);
            end
        end
    end

    // Capture the item with a snapshot of the window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s_acc) begin
            s1_cur_reg <= s_tdata;
            for (int i = 0; i < WinDepth; i++) s1_win_reg[i] <= win_reg[i];
            s1_pos_reg <= pos_reg;
        end
    end

    // Match logic
    logic [7:0]  b1, b2, b3, b4, b5;
    logic [31:0] word;
    logic [15:0] th_hi, th_lo;
    logic        slot_hit, call_hit, a64_hit, th_hit;
    logic        th_s, th_i1, th_i2;
    logic [24:0] th_v;
    logic [RelW-1:0]    rel;
    logic [PosBits:0]   off;
    logic [63:0]        base_sel;
    logic [SumW-1:0]    sum;
    logic               in_range;
    logic [PosBits-1:0] p;

    always_comb begin
        p     = s1_pos_reg;
        b1    = s1_win_reg[0];
        b2    = s1_win_reg[1];
        b3    = s1_win_reg[2];
        b4    = s1_win_reg[3];
        b5    = s1_win_reg[4];
        word  = {s1_cur_reg, b1, b2, b3};
        th_hi = {b2, b3};
        th_lo = {s1_cur_reg, b1};

        slot_hit = (mode_reg == MODE_X86) && (p >= PosBits'(5)) &&
                   (b5 == X86_GRP5_OP) && (b4 == X86_MODRM_RIP);
        call_hit = (mode_reg == MODE_X86) && (p >= PosBits'(4)) &&
                   (b4 == X86_CALL_OP);
        a64_hit  = (mode_reg == MODE_A64) && (p >= PosBits'(3)) &&
                   (p[1:0] == 2'b11) && ((word & A64_B_MASK) == A64_B_MATCH);
        th_hit   = (mode_reg == MODE_THUMB) && (p >= PosBits'(3)) && p[0] &&
                   ((th_hi & T2_HI_MASK) == T2_HI_MATCH) &&
                   ((th_lo & T2_LO_MASK) == T2_LO_MASK);

        // Thumb displacement with inverted J bits
        th_s  = th_hi[10];
        th_i1 = ~(th_lo[13] ^ th_s);
        th_i2 = ~(th_lo[11] ^ th_s);
        th_v  = {th_s, th_i1, th_i2, th_hi[9:0], th_lo[10:0], 1'b0};

        // Select operands for the shared target adder
        case (mode_reg)
            MODE_A64: begin
                rel      = {{5{word[25]}}, word[25:0], 2'b00};
                off      = {1'b0, p - PosBits'(3)};
                base_sel = base_reg;
            end
            MODE_THUMB: begin
                rel      = {{(RelW-25){th_v[24]}}, th_v};
                off      = {1'b0, p} + (PosBits+1)'(1);
                base_sel = {base_reg[63:1], 1'b0};
            end
            default: begin
                rel      = {word[31], word};
                off      = {1'b0, p} + (PosBits+1)'(1);
                base_sel = base_reg;
            end
        endcase

        // Exact sum; anything outside 64 bits is dropped
        sum = {2'b00, base_sel} + {{(SumW-PosBits-1){1'b0}}, off} +
              {{(SumW-RelW){rel[RelW-1]}}, rel};
        in_range = (sum[SumW-1:64] == '0);
    end

    // Build result entries for this item
    res_t r_slot, r_call, r_a64, r_th;
    logic [1:0] n_res;
    res_t       n0, n1;

    always_comb begin
        r_slot = '{target: sum[63:0], kind: KIND_X86_SLOT,
                   start: 32'(p - PosBits'(5)), last: 1'b1};
        r_call = '{target: sum[63:0], kind: KIND_X86_CALL,
                   start: 32'(p - PosBits'(4)), last: 1'b1};
        r_a64  = '{target: sum[63:0], kind: KIND_A64_B,
                   start: 32'(p - PosBits'(3)), last: 1'b1};
        r_th   = '{target: sum[63:0], kind: KIND_THUMB_BL,
                   start: 32'(p - PosBits'(3)), last: 1'b1};
        n0 = r_call;
        n1 = r_call;
        n_res = 2'd0;
        if (in_range) begin
            if (slot_hit && call_hit) begin
                n0      = r_slot;
                n0.last = 1'b0;
                n_res   = 2'd2;
            end else if (slot_hit) begin
                n0    = r_slot;
                n_res = 2'd1;
            end else if (call_hit) begin
                n_res = 2'd1;
            end else if (a64_hit) begin
                n0    = r_a64;
                n_res = 2'd1;
            end else if (th_hit) begin
                n0    = r_th;
                n_res = 2'd1;
            end
        end
    end

    // Result buffer: load when drained, else shift on pop
    always_comb begin
        cnt_next = cnt_after_pop;
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        if (load) begin
            cnt_next = n_res;
            e0_next  = n0;
            e1_next  = n1;
        end else if (pop) begin
            e0_next = e1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    // Drive result channel from the buffer head
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {e0_reg.start, e0_reg.target};
    assign m_tuser  = e0_reg.kind;
    assign m_tlast  = e0_reg.last;

endmodule

// File: test/branch_target_checker.sv
// ----------------------------------------------------------------------------
// branch_target_checker
// Watches the code byte and result streams of the branch target scanner,
// mirrors its window, position and registers, predicts the targets each byte
// reveals and compares every result item field by field in order.
// ----------------------------------------------------------------------------
module branch_target_checker
    import dbts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          pending_results,
    output int          mismatch_count
);

    // Mirror of the scanner state
    logic [1:0]         arch_mode;
    logic [63:0]        body_base;
    logic [7:0]         history [WinDepth];
    logic [PosBits-1:0] body_pos;
    res_t               expected_targets [$];

    initial mismatch_count = 0;

    // Exact base + offset + signed displacement, wide enough to see overflow
    function automatic logic [SumW-1:0] exact_sum(input logic [63:0] base,
                                                  input logic [PosBits:0] off,
                                                  input logic [RelW-1:0] rel);
        return {2'b00, base} + {{(SumW-PosBits-1){1'b0}}, off} +
               {{(SumW-RelW){rel[RelW-1]}}, rel};
    endfunction

    // Queue a target unless the exact sum falls outside 64 bits
    task automatic push_target(input logic [SumW-1:0] sum, input logic [1:0] kind,
                               input logic [PosBits-1:0] start);
        res_t r;
        if (sum[SumW-1:64] == '0) begin
            r.target = sum[63:0];
            r.kind   = kind;
            r.start  = start[31:0];
            r.last   = 1'b0;
            expected_targets.insert(expected_targets.size(), r);
        end
    endtask

    // Work out the targets revealed by one code byte, then advance the window
    task automatic predict_targets(input logic [7:0] cur, input logic last_byte);
        logic [7:0]         b [6];
        logic [31:0]        w;
        logic [15:0]        hw;
        logic [15:0]        lw;
        logic [24:0]        tv;
        logic               s;
        logic [PosBits:0]   next_off;
        logic [PosBits-1:0] p;
        int                 first_new;
        p = body_pos;
        b[0] = cur;
        for (int k = 1; k < 6; k++) b[k] = history[k-1];
        first_new = expected_targets.size();
        w = {b[0], b[1], b[2], b[3]};
        next_off = {1'b0, p} + 1'b1;
        case (arch_mode)
            MODE_X86: begin
                if (p >= 5 && b[5] == X86_GRP5_OP && b[4] == X86_MODRM_RIP)
                    push_target(exact_sum(body_base, next_off, {w[31], w}),
                                KIND_X86_SLOT, p - 5);
                if (p >= 4 && b[4] == X86_CALL_OP)
                    push_target(exact_sum(body_base, next_off, {w[31], w}),
                                KIND_X86_CALL, p - 4);
            end
            MODE_A64: begin
                if (p >= 3 && p[1:0] == 2'b11 && (w & A64_B_MASK) == A64_B_MATCH)
                    push_target(exact_sum(body_base, {1'b0, p - 3'd3},
                                          {{5{w[25]}}, w[25:0], 2'b00}),
                                KIND_A64_B, p - 3);
            end
            MODE_THUMB: begin
                hw = {b[2], b[3]};
                lw = {b[0], b[1]};
                if (p >= 3 && p[0] && (hw & T2_HI_MASK) == T2_HI_MATCH &&
                    (lw & T2_LO_MASK) == T2_LO_MASK) begin
                    // J bits are stored inverted against the sign
                    s  = hw[10];
                    tv = {s, ~(lw[13] ^ s), ~(lw[11] ^ s), hw[9:0], lw[10:0], 1'b0};
                    push_target(exact_sum({body_base[63:1], 1'b0}, next_off,
                                          {{(RelW-25){tv[24]}}, tv}),
                                KIND_THUMB_BL, p - 3);
                end
            end
            default: ;
        endcase
        if (expected_targets.size() > first_new)
            expected_targets[expected_targets.size()-1].last = 1'b1;
        // Clear at end of body, else shift the byte in
        if (last_byte) begin
            for (int k = 0; k < WinDepth; k++) history[k] = '0;
            body_pos = '0;
        end else begin
            for (int k = WinDepth - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = cur;
            body_pos = p + 1'b1;
        end
    endtask

    task automatic note_mismatch(input string what, input res_t exp, input res_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: exp %h kind %0d start %0d last %b / got %h kind %0d start %0d last %b",
                     what, exp.target, exp.kind, exp.start, exp.last,
                     got.target, got.kind, got.start, got.last);
    endtask

    // Compare results, predict from bytes, follow register writes
    always @(posedge aclk) begin
        res_t got;
        res_t exp;
        if (!aresetn) begin
            arch_mode = MODE_NONE;
            body_base = '0;
            for (int k = 0; k < WinDepth; k++) history[k] = '0;
            body_pos = '0;
            expected_targets.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.target = m_tdata[63:0];
                got.kind   = m_tuser;
                got.start  = m_tdata[95:64];
                got.last   = m_tlast;
                if (expected_targets.size() == 0) begin
                    exp = '0;
                    note_mismatch("unexpected result", exp, got);
                end else begin
                    exp = expected_targets.pop_front();
                    if (got.target !== exp.target || got.kind !== exp.kind ||
                        got.start !== exp.start || got.last !== exp.last)
                        note_mismatch("result mismatch", exp, got);
                end
            end
            if (s_tvalid && s_tready)
                predict_targets(s_tdata, s_tlast);
            if (cfg_we) begin
                if (cfg_index == CFG_ARCH_MODE)
                    arch_mode = cfg_data[1:0];
                else
                    body_base = cfg_data;
            end
        end
        pending_results <= expected_targets.size();
    end

endmodule

// File: test/tb_direct_branch_target_scanner_unit.sv
// ----------------------------------------------------------------------------
// tb_direct_branch_target_scanner_unit
// Feeds code bodies to the branch target scanner under every decode mode and
// a range of base addresses: a few hand-made bodies, then random bodies built
// mostly from well-formed branch encodings, with random gaps on both streams.
// A checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_direct_branch_target_scanner_unit;
    import dbts_pkg::*;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_ARCH_MODE;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] code_byte
    logic        s_tlast   = 1'b0;  // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;           // [63:0] target_address, [95:64] start_offset
    logic [1:0]  m_tuser;           // [1:0] match_kind
    logic        m_tlast;           // run_last
    int          pending_results;
    int          mismatch_count;

    bit          steady = 1'b0;
    logic [7:0]  body_bytes [$];

    direct_branch_target_scanner_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    branch_target_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .pending_results(pending_results),
        .mismatch_count (mismatch_count)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Displacement with a bias toward the signed extremes
    function automatic logic [31:0] pick_disp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'h7fff_ffff;
        if (r < 20) return 32'h8000_0000;
        if (r < 30) return 32'hffff_ffff;
        if (r < 35) return 32'h0;
        if (r < 65) return 32'($urandom_range(0, 255)) - 32'd128;
        return $urandom;
    endfunction

    function automatic logic [63:0] pick_base();
        case ($urandom_range(0, 6))
            0: return 64'h0;
            1: return '1;
            2: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 4095));
            3: return 64'h8000_0000_0000_0000;
            4: return 64'($urandom_range(0, 65535));
            5: return 64'h7fff_ffff_8000_0000 + 64'($urandom_range(0, 4095));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Append one byte to the body
    task automatic add_byte(input logic [7:0] v);
        body_bytes.insert(body_bytes.size(), v);
    endtask

    // Append the low n bytes of v, lowest first
    task automatic push_bytes(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
    endtask

    // Build one random body for the given mode
    task automatic build_body(input logic [1:0] mode);
        int          units;
        int          r;
        bit          noise;
        logic [31:0] w;
        logic [15:0] hi;
        logic [15:0] lo;
        units = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(30, 80);
        noise = (mode == MODE_NONE) || ($urandom_range(0, 99) < 15);
        repeat (units) begin
            r = $urandom_range(0, 99);
            w = $urandom;
            if (noise) begin
                push_bytes(w, $urandom_range(1, 4));
            end else begin
                case (mode)
                    MODE_X86: begin
                        if (r < 40) begin
                            add_byte(X86_CALL_OP);
                            push_bytes(pick_disp(), 4);
                        end else if (r < 70) begin
                            add_byte(X86_GRP5_OP);
                            add_byte(X86_MODRM_RIP);
                            push_bytes(pick_disp(), 4);
                        end else if (r < 80) begin
                            add_byte(w[0] ? X86_CALL_OP : X86_GRP5_OP);
                        end else begin
                            push_bytes(w, $urandom_range(1, 3));
                        end
                    end
                    MODE_A64: begin
                        if (r < 60) begin
                            w = (w & ~A64_B_MASK) | A64_B_MATCH;
                            case ($urandom_range(0, 5))
                                0: w[25:0] = 26'h1ff_ffff;
                                1: w[25:0] = 26'h200_0000;
                                2: w[25:0] = 26'h3ff_ffff;
                                default: ;
                            endcase
                            push_bytes(w, 4);
                        end else if (r < 90) begin
                            push_bytes(w, 4);
                        end else begin
                            // knock the word alignment off
                            push_bytes(w, $urandom_range(1, 3));
                        end
                    end
                    MODE_THUMB: begin
                        if (r < 60) begin
                            hi = T2_HI_MATCH | (w[15:0] & ~T2_HI_MASK);
                            lo = T2_LO_MASK | (w[31:16] & ~T2_LO_MASK);
                            push_bytes({lo, hi}, 4);
                        end else if (r < 85) begin
                            push_bytes(w, 2);
                        end else begin
                            push_bytes(w, 1);
                        end
                    end
                    default: ;
                endcase
            end
        end
        // Cut some bodies short in the middle of an instruction
        if (body_bytes.size() > 4 && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) void'(body_bytes.pop_back());
    endtask

    // Send the queued bytes; mark the final one as end of body if asked
    task automatic send_body(input bit close);
        int gap;
        while (body_bytes.size() > 0) begin
            gap = steady ? 0 : pick_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= body_bytes[0];
            s_tlast  <= close && (body_bytes.size() == 1);
            void'(body_bytes.pop_front());
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
    endtask

    // Stop sending and let every expected result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [63:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ARCH_MODE;
        cfg_data  <= {62'b0, mode};
        @(posedge aclk);
        cfg_index <= CFG_BODY_BASE;
        cfg_data  <= base;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side backpressure
    initial begin : result_sink
        int run;
        int stall;
        forever begin
            run = $urandom_range(1, 30);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = steady ? 0 : pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin : run_limit
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        int          sent_bytes;
        int          phase_bytes;
        int          phase_size;
        logic [1:0]  mode;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // x86 near the top of the address space: call back by one, slot at -2^31
        set_config(MODE_X86, 64'hffff_ffff_ffff_fff8);
        body_bytes = '{8'he8, 8'hff, 8'hff, 8'hff, 8'hff,
                       8'hff, 8'h15, 8'h00, 8'h00, 8'h00, 8'h80};
        send_body(1'b1);
        drain();

        // A64 at base zero: BL to -4 is dropped, B +4 lands at 8
        set_config(MODE_A64, 64'h0);
        body_bytes = '{8'hff, 8'hff, 8'hff, 8'h97, 8'h01, 8'h00, 8'h00, 8'h14};
        send_body(1'b1);
        drain();

        // Thumb with odd base: bit 0 is cleared, branch back to its own start
        set_config(MODE_THUMB, 64'h1);
        body_bytes = '{8'hff, 8'hf7, 8'hfe, 8'hff};
        send_body(1'b1);
        drain();

        // Random phases, each with its own mode and base
        sent_bytes = 0;
        phase = 0;
        while (sent_bytes < 1900) begin
            mode = 2'(phase % 4);
            steady = (phase % 5 == 3);
            set_config(mode, pick_base());
            phase_size = (mode == MODE_NONE) ? 40 : 150;
            phase_bytes = 0;
            while (phase_bytes < phase_size) begin
                build_body(mode);
                phase_bytes += body_bytes.size();
                // sometimes leave the body open across the next register write
                send_body(phase_bytes < phase_size || $urandom_range(0, 3) != 0);
            end
            sent_bytes += phase_bytes;
            drain();
            phase++;
        end

        steady = 1'b0;
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
design/dbts_pkg.sv
design/direct_branch_target_scanner_unit.sv
test/branch_target_checker.sv
test/tb_direct_branch_target_scanner_unit.sv
